// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define SIST_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define SIST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/sist_pkg.sv
// types and constants of the integer set table
`timescale 1ns / 1ps

package sist_pkg;

    localparam int VALUE_W      = 32;
    localparam int OCC_W        = 5;
    localparam int DEF_CAPACITY = 16;

    // request kinds
    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_LOOKUP = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    // controls broadcast along the cell row
    typedef struct packed {
        logic cmp_en;
        logic shift_up;
        logic shift_down;
    } t_cell_ctrl;

endpackage

// File: rtl/sist_if.sv
// request and response channel interfaces of the integer set table
`timescale 1ns / 1ps

interface sist_req_if;
    import sist_pkg::*;

    logic                      valid;
    logic                      ready;
    t_func                     func;
    logic signed [VALUE_W-1:0] item_value;

    modport source (output valid, output func, output item_value, input ready);
    modport sink   (input valid, input func, input item_value, output ready);
endinterface

interface sist_rsp_if;
    import sist_pkg::*;

    logic             valid;
    logic             ready;
    logic             was_present;
    logic             succeeded;
    logic             full_refused;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output was_present, output succeeded,
                    output full_refused, output occupancy, input ready);
    modport sink   (input valid, input was_present, input succeeded,
                    input full_refused, input occupancy, output ready);
endinterface

// File: rtl/sist_cell.sv
// one slot of the set: stored value, match flag and neighbour shifting
`timescale 1ns / 1ps

module sist_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                         i_clk,
    input  sist_pkg::t_cell_ctrl         i_ctrl,
    input  logic [CNT_W-1:0]             i_count,
    input  logic [sist_pkg::VALUE_W-1:0] i_value,
    input  logic [sist_pkg::VALUE_W-1:0] i_prev_entry,
    input  logic [sist_pkg::VALUE_W-1:0] i_next_entry,
    input  logic                         i_ge,
    output logic                         o_ge,
    output logic [sist_pkg::VALUE_W-1:0] o_entry
);
    import sist_pkg::*;

    logic [VALUE_W-1:0] r_entry;
    logic               r_match;
    logic               w_live;

    // slot holds a value only below the occupancy count
    assign w_live = (i_count > CNT_W'(INDEX));

    // matched slot or any slot past it in the row
    assign o_ge    = i_ge | r_match;
    assign o_entry = r_entry;

    // compare, then insert from below or close the gap from above
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= w_live && (r_entry == i_value);
        end
        if (i_ctrl.shift_up) begin
            r_entry <= i_prev_entry;
        end else if (i_ctrl.shift_down && o_ge) begin
            r_entry <= i_next_entry;
        end
    end

endmodule

// File: rtl/small_integer_set_table.sv
// top level of the integer set table: sequencer, count and cell row
`timescale 1ns / 1ps

// Set of up to CAPACITY distinct 32-bit values with an occupancy count.
// Request channel i_req carries func (add, remove, lookup, clear) and
// item_value; response channel o_rsp returns was_present, succeeded,
// full_refused and the occupancy after the request, one per request.
// Both channels move a transaction when valid and ready are high together.
// A request is registered on acceptance; in S_CMP every cell compares its
// value with it, and in S_UPD the row updates and the response is
// registered. The next request is taken on the same edge that registers
// the response. Add shifts every cell up by one and writes the value
// into the first cell; remove shifts the cells from the matched one
// onwards down by one, so stored order is kept. Reset (synchronous,
// active low) empties the set and drops any pending response; stored
// values are not cleared. While the receiver stalls, the response is held
// and one more request may be taken; it then waits in its update pass
// until the response register frees.
module small_integer_set_table #(
    parameter int CAPACITY = sist_pkg::DEF_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sist_req_if.sink         i_req,
    sist_rsp_if.source       o_rsp
);
    import sist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state             r_state;
    t_func              r_func;
    logic [VALUE_W-1:0] r_value;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               r_was_present;
    logic               r_succeeded;
    logic               r_full_refused;
    logic               n_was_present;
    logic               n_succeeded;
    logic               n_full_refused;

    logic               w_out_free;
    logic               w_advance;
    logic               w_accept;
    logic               w_present;
    logic               w_has_room;
    t_cell_ctrl         w_ctrl;

    logic [CAPACITY:0]  w_ge;
    logic [VALUE_W-1:0] w_entry [CAPACITY];
    logic [OCC_W+CNT_W-1:0] w_count_ext;

    // handshake
    assign w_out_free    = !r_out_valid || o_rsp.ready;
    assign w_advance     = (r_state == S_UPD) && w_out_free;
    assign i_req.ready   = (r_state == S_IDLE) || w_advance;
    assign w_accept      = i_req.valid && i_req.ready;

    // match chain end tells whether any live cell held the value
    assign w_ge[0]    = 1'b0;
    assign w_present  = w_ge[CAPACITY];
    assign w_has_room = (r_count < CNT_W'(CAPACITY));

    // row controls
    always_comb begin
        w_ctrl.cmp_en     = (r_state == S_CMP);
        w_ctrl.shift_up   = w_advance && (r_func == FN_ADD) && !w_present && w_has_room;
        w_ctrl.shift_down = w_advance && (r_func == FN_REMOVE) && w_present;
    end

    // response fields and next count
    always_comb begin
        n_count        = r_count;
        n_was_present  = w_present;
        n_succeeded    = 1'b0;
        n_full_refused = 1'b0;
        unique case (r_func)
            FN_ADD: begin
                if (!w_present) begin
                    if (w_has_room) begin
                        n_succeeded = 1'b1;
                        n_count     = r_count + CNT_W'(1);
                    end else begin
                        n_full_refused = 1'b1;
                    end
                end
            end
            FN_REMOVE: begin
                if (w_present) begin
                    n_succeeded = 1'b1;
                    n_count     = r_count - CNT_W'(1);
                end
            end
            FN_LOOKUP: begin
                n_succeeded = w_present;
            end
            FN_CLEAR: begin
                n_was_present = 1'b0;
                n_succeeded   = 1'b1;
                n_count       = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // sequencer, count and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_func  <= i_req.func;
                r_value <= i_req.item_value;
            end
            if (w_advance) begin
                r_count        <= n_count;
                r_out_valid    <= 1'b1;
                r_was_present  <= n_was_present;
                r_succeeded    <= n_succeeded;
                r_full_refused <= n_full_refused;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_advance) begin
                        r_state <= w_accept ? S_CMP : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] w_prev;
        logic [VALUE_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = r_value;
        end else begin : g_inner_prev
            assign w_prev = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_inner_next
            assign w_next = w_entry[g+1];
        end

        sist_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_count      (r_count),
            .i_value      (r_value),
            .i_prev_entry (w_prev),
            .i_next_entry (w_next),
            .i_ge         (w_ge[g]),
            .o_ge         (w_ge[g+1]),
            .o_entry      (w_entry[g])
        );
    end

    // response outputs, occupancy in its low bits
    assign w_count_ext        = {{OCC_W{1'b0}}, r_count};
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.was_present  = r_was_present;
    assign o_rsp.succeeded    = r_succeeded;
    assign o_rsp.full_refused = r_full_refused;
    assign o_rsp.occupancy    = w_count_ext[OCC_W-1:0];

endmodule

// File: rtl/sist_checker.sv
// port-level checks of the integer set table and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sist_checker #(
    parameter int CAPACITY = sist_pkg::DEF_CAPACITY
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_was_present,
    input logic                       i_succeeded,
    input logic                       i_full_refused,
    input logic [sist_pkg::OCC_W-1:0] i_occupancy
);
    import sist_pkg::*;

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CAPACITY);

    // a stalled response stays up
    `SIST_ASSERT_CLK(a_rsp_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready |=> i_out_valid), "response dropped while stalled")

    // two requests never land on consecutive edges
    `SIST_ASSERT_CLK(a_req_spacing, i_clk, i_rst_n, (i_in_valid && i_in_ready |=> !i_in_ready), "request taken one cycle after another")

    // a refused add leaves the set full and reports nothing else
    `SIST_ASSERT_CLK(a_refuse_full, i_clk, i_rst_n, (i_out_valid && i_full_refused |-> !i_succeeded && !i_was_present && (i_occupancy == FULL_OCC)), "refused add with wrong flags")

    // no response straight after reset
    `SIST_ASSERT_ALWAYS(a_rst_quiet, i_clk, (!i_rst_n |=> !i_out_valid), "response valid after reset")

endmodule

bind small_integer_set_table sist_checker #(
    .CAPACITY (CAPACITY)
) u_sist_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_was_present  (o_rsp.was_present),
    .i_succeeded    (o_rsp.succeeded),
    .i_full_refused (o_rsp.full_refused),
    .i_occupancy    (o_rsp.occupancy)
);

// File: verif/small_integer_set_table_test.sv
// self-checking testbench for the integer set table with a membership scoreboard
`timescale 1ns / 1ps

// tracks the set as requests are accepted and checks each response against it
class membership_tracker;
    localparam int CAPACITY = sist_pkg::DEF_CAPACITY;

    typedef struct {
        logic                         was_present;
        logic                         succeeded;
        logic                         full_refused;
        logic [sist_pkg::OCC_W-1:0]   occupancy;
    } t_reply;

    logic [sist_pkg::VALUE_W-1:0] members [CAPACITY];
    int unsigned                  member_count;
    t_reply                       expected_replies [$];
    int unsigned                  mismatches;

    function new();
        member_count = 0;
        mismatches   = 0;
    endfunction

    // apply one accepted request to the tracked set and queue its reply
    function void note_request(sist_pkg::t_func kind, logic [sist_pkg::VALUE_W-1:0] value);
        t_reply r;
        int     slot;
        r.was_present  = 1'b0;
        r.succeeded    = 1'b0;
        r.full_refused = 1'b0;
        slot           = -1;
        if (kind == sist_pkg::FN_CLEAR) begin
            // only the count goes; stale values must not match afterwards
            member_count = 0;
            r.succeeded  = 1'b1;
        end else begin
            for (int i = 0; i < member_count; i++) begin
                if (slot < 0 && members[i] == value) slot = i;
            end
            r.was_present = (slot >= 0);
            case (kind)
                sist_pkg::FN_ADD: begin
                    if (slot < 0) begin
                        if (member_count < CAPACITY) begin
                            members[member_count] = value;
                            member_count++;
                            r.succeeded = 1'b1;
                        end else begin
                            r.full_refused = 1'b1;
                        end
                    end
                end
                sist_pkg::FN_REMOVE: begin
                    if (slot >= 0) begin
                        members[slot] = members[member_count - 1];
                        member_count--;
                        r.succeeded = 1'b1;
                    end
                end
                default: r.succeeded = r.was_present;
            endcase
        end
        r.occupancy = member_count[sist_pkg::OCC_W-1:0];
        expected_replies.push_back(r);
    endfunction

    // compare one accepted response with the oldest queued reply
    function void check_reply(logic was_present, logic succeeded, logic full_refused,
                              logic [sist_pkg::OCC_W-1:0] occupancy);
        t_reply e;
        if (expected_replies.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatches++;
            return;
        end
        e = expected_replies.pop_front();
        if (was_present !== e.was_present) begin
            $error("was_present: expected %0b, got %0b", e.was_present, was_present);
            mismatches++;
        end
        if (succeeded !== e.succeeded) begin
            $error("succeeded: expected %0b, got %0b", e.succeeded, succeeded);
            mismatches++;
        end
        if (full_refused !== e.full_refused) begin
            $error("full_refused: expected %0b, got %0b", e.full_refused, full_refused);
            mismatches++;
        end
        if (occupancy !== e.occupancy) begin
            $error("occupancy: expected %0d, got %0d", e.occupancy, occupancy);
            mismatches++;
        end
    endfunction

    function int unsigned outstanding();
        return expected_replies.size();
    endfunction
endclass

module small_integer_set_table_test;
    import sist_pkg::*;

    localparam int CAPACITY    = DEF_CAPACITY;
    localparam int RANDOM_REQS = 850;
    localparam int POOL_SIZE   = 24;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        no_idle;
    int unsigned cycle_count;
    int unsigned stall_left;
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    membership_tracker set_model = new();

    sist_req_if req_ch ();
    sist_rsp_if rsp_ch ();

    small_integer_set_table #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run guard
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // response side: check accepted transactions, stall at random
    initial begin
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                set_model.check_reply(rsp_ch.was_present, rsp_ch.succeeded,
                                      rsp_ch.full_refused, rsp_ch.occupancy);
            end
            if (stall_left > 0 && !no_idle) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // one request transaction, with an optional idle gap ahead of it
    task automatic send_request(input t_func kind, input logic [VALUE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= kind;
        req_ch.item_value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        set_model.note_request(kind, value);
    endtask

    // random request kind, weighted by how fast the set should grow
    function automatic t_func pick_kind(int add_weight);
        int r;
        r = $urandom_range(99);
        if (r < 3) return FN_CLEAR;
        if (r < 3 + add_weight) return FN_ADD;
        if (r < 3 + add_weight + (97 - add_weight) / 2) return FN_REMOVE;
        return FN_LOOKUP;
    endfunction

    // main sequence
    initial begin
        int          add_weight;
        t_func       kind;
        logic [VALUE_W-1:0] value;

        i_rst_n           <= 1'b0;
        no_idle           = 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FN_LOOKUP;
        req_ch.item_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty set, extremes, duplicates, fill to full, clear
        send_request(FN_CLEAR,  32'h7fff_ffff);
        send_request(FN_LOOKUP, 32'h8000_0000);
        send_request(FN_REMOVE, 32'h0000_0000);
        send_request(FN_ADD,    32'h8000_0000);
        send_request(FN_ADD,    32'h7fff_ffff);
        send_request(FN_ADD,    32'h8000_0000);
        send_request(FN_LOOKUP, 32'h7fff_ffff);
        send_request(FN_LOOKUP, 32'hffff_ffff);
        send_request(FN_REMOVE, 32'h8000_0000);
        send_request(FN_ADD,    32'h0000_0000);
        send_request(FN_ADD,    32'hffff_ffff);
        for (int k = 1; k <= 13; k++) send_request(FN_ADD, k);
        // full now: new value refused, present value just reported
        send_request(FN_ADD,    32'h1234_5678);
        send_request(FN_ADD,    32'h0000_0000);
        send_request(FN_REMOVE, 32'hffff_ffff);
        send_request(FN_ADD,    32'h1234_5678);
        send_request(FN_CLEAR,  32'h0000_0000);
        // stale stored value must read as absent after clear
        send_request(FN_LOOKUP, 32'h7fff_ffff);

        // random: values mostly from a small pool so hits and full sets are common
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int k = 4; k < POOL_SIZE; k++) value_pool[k] = $urandom;
        add_weight = 40;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 150 == 0) begin
                case ($urandom_range(2))
                    0: add_weight = 60;
                    1: add_weight = 40;
                    default: add_weight = 25;
                endcase
                for (int k = 0; k < 6; k++) value_pool[$urandom_range(POOL_SIZE-1)] = $urandom;
            end
            no_idle = (n >= 400 && n < 520);
            kind = pick_kind(add_weight);
            if (kind == FN_CLEAR || $urandom_range(9) == 0) value = $urandom;
            else value = value_pool[$urandom_range(POOL_SIZE-1)];
            send_request(kind, value);
        end
        req_ch.valid <= 1'b0;

        // drain, then give a stray response time to show
        while (set_model.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (set_model.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/sist_pkg.sv
rtl/sist_if.sv
rtl/sist_cell.sv
rtl/small_integer_set_table.sv
rtl/sist_checker.sv
verif/small_integer_set_table_test.sv
